### design/waypoint_pattern_generator_assert.svh
// assertion macros for the waypoint pattern generator checker
`ifndef WAYPOINT_PATTERN_GENERATOR_ASSERT_SVH
`define WAYPOINT_PATTERN_GENERATOR_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define WPG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("waypoint pattern generator check failed");

// next-cycle implication, sampled on clk, off during reset
`define WPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("waypoint pattern generator check failed");

`endif

### design/wpg_pkg.sv
// shared constants, types and the cordic angle table of the waypoint pattern generator
package wpg_pkg;

  localparam int MAX_POINTS_DEF   = 64;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_SHAPE_MODE      = 3'd0,
    REG_CENTER_X        = 3'd1,
    REG_CENTER_Y        = 3'd2,
    REG_CENTER_Z        = 3'd3,
    REG_SHAPE_SIZE      = 3'd4,
    REG_POINTS_PER_CYC  = 3'd5,
    REG_START_AT_CENTER = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_LINE   = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_CIRCLE = 2'd2
  } mode_t;

  localparam logic [1:0]  RST_SHAPE_MODE = 2'd2;
  localparam logic [14:0] RST_CENTER_X   = 15'd11469;
  localparam logic [14:0] RST_CENTER_Y   = 15'd0;
  localparam logic [14:0] RST_CENTER_Z   = 15'd14746;
  localparam logic [12:0] RST_SHAPE_SIZE = 13'd1638;
  localparam logic [6:0]  RST_PPC        = 7'd8;
  localparam logic        RST_SAC        = 1'b1;

  // cordic gain in q30
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_init;
    logic div_step;
    logic angle;
    logic rot_step;
    logic emit;
    logic [4:0] k;
  } cmd_t;

  typedef struct packed {
    logic is_direct;
    logic is_line;
    logic out_free;
  } status_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### design/wpg_if.sv
// valid/ready channel interfaces: tick request, point result, configuration write
interface wpg_tick_if;
  logic valid;
  logic ready;
  logic tick;
  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
  modport mon    (input valid, input tick, input ready);
endinterface

interface wpg_point_if;
  logic               valid;
  logic               ready;
  logic        [14:0] target_x;
  logic signed [14:0] target_y;
  logic        [14:0] target_z;
  logic        [6:0]  point_number;
  logic        [6:0]  point_count;
  modport source (output valid, output target_x, output target_y, output target_z,
                  output point_number, output point_count, input ready);
  modport sink   (input valid, input target_x, input target_y, input target_z,
                  input point_number, input point_count, output ready);
  modport mon    (input valid, input target_x, input target_y, input target_z,
                  input point_number, input point_count, input ready);
endinterface

interface wpg_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  reg_index;
  logic [14:0] data;
  modport source (output valid, output reg_index, output data, input ready);
  modport sink   (input valid, input reg_index, input data, output ready);
endinterface

### design/wpg_ctrl.sv
// sequencing state machine: setup, serial divide, cordic rotation, result hand-off
module wpg_ctrl #(
  parameter int DIV_STEPS    = 40,
  parameter int CORDIC_STEPS = wpg_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick_req,
  input  wpg_pkg::status_t st,
  output logic             in_ready,
  output wpg_pkg::cmd_t    cmd
);

  localparam int MAXS = (DIV_STEPS > CORDIC_STEPS) ? DIV_STEPS : CORDIC_STEPS;
  localparam int CNTW = $clog2(MAXS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_DIVI  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_ANGLE = 7'b0010000,
    S_ROT   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (tick_req) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = st.is_direct ? S_DONE : S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNTW'(DIV_STEPS - 1)) begin
          state_nxt = st.is_line ? S_DONE : S_ANGLE;
        end
      end
      S_ANGLE: begin
        cmd.angle = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        cmd.k        = 5'(cnt_r);
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNTW'(CORDIC_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

### design/wpg_dp.sv
// datapath: config registers, position index, serial divider, cordic, output register
module wpg_dp #(
  parameter int MAX_POINTS = wpg_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wpg_pkg::cmd_t       cmd,
  output wpg_pkg::status_t    st,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [14:0]         cfg_data,
  input  logic                out_ready,
  output logic                out_valid,
  output logic        [14:0]  target_x,
  output logic signed [14:0]  target_y,
  output logic        [14:0]  target_z,
  output logic        [6:0]   point_number,
  output logic        [6:0]   point_count
);

  localparam int CW  = $clog2(MAX_POINTS + 2);
  localparam int SW  = CW + 2;
  localparam int MW  = SW + 14;
  localparam int DDW = CW + 33;
  localparam int DVW = CW + 1;
  localparam int ZW  = 34;
  localparam int OW  = 18;

  // configuration
  logic [1:0]         shape_mode_r;
  logic [14:0]        center_x_r;
  logic signed [14:0] center_y_r;
  logic [14:0]        center_z_r;
  logic [12:0]        shape_size_r;
  logic [6:0]         ppc_r;
  logic               sac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_mode_r <= wpg_pkg::RST_SHAPE_MODE;
      center_x_r   <= wpg_pkg::RST_CENTER_X;
      center_y_r   <= wpg_pkg::RST_CENTER_Y;
      center_z_r   <= wpg_pkg::RST_CENTER_Z;
      shape_size_r <= wpg_pkg::RST_SHAPE_SIZE;
      ppc_r        <= wpg_pkg::RST_PPC;
      sac_r        <= wpg_pkg::RST_SAC;
    end else if (cfg_we) begin
      case (cfg_index)
        wpg_pkg::REG_SHAPE_MODE:      shape_mode_r <= cfg_data[1:0];
        wpg_pkg::REG_CENTER_X:        center_x_r   <= cfg_data;
        wpg_pkg::REG_CENTER_Y:        center_y_r   <= cfg_data;
        wpg_pkg::REG_CENTER_Z:        center_z_r   <= cfg_data;
        wpg_pkg::REG_SHAPE_SIZE:      shape_size_r <= cfg_data[12:0];
        wpg_pkg::REG_POINTS_PER_CYC:  ppc_r        <= cfg_data[6:0];
        wpg_pkg::REG_START_AT_CENTER: sac_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // point selection
  logic [CW-1:0] idx_r;
  logic [CW-1:0] n_c, pat_c, cnt_c, pos_c;
  logic [CW-1:0] n_r, cnt_r, pos_r, i_r;
  logic          center_r, line_r, square_r;

  always_comb begin
    if (ppc_r < 7'd4) n_c = CW'(4);
    else if (32'(ppc_r) > MAX_POINTS) n_c = CW'(MAX_POINTS);
    else n_c = CW'(ppc_r);
    pat_c = (shape_mode_r == wpg_pkg::MODE_SQUARE) ? CW'(4) : n_c;
    cnt_c = pat_c + CW'(sac_r);
    pos_c = (idx_r < cnt_c) ? idx_r : '0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r      <= n_c;
      cnt_r    <= cnt_c;
      pos_r    <= pos_c;
      i_r      <= pos_c - CW'(sac_r);
      center_r <= sac_r && (pos_c == '0);
      line_r   <= (shape_mode_r == wpg_pkg::MODE_LINE);
      square_r <= (shape_mode_r == wpg_pkg::MODE_SQUARE);
    end
  end

  // line numerator (2i-(n-1))*size
  logic signed [SW-1:0] a_s;
  logic signed [MW-1:0] prod_s;
  logic [MW-1:0]        mag_r;
  logic                 neg_r;

  assign a_s    = signed'({1'b0, i_r, 1'b0}) - signed'({2'b00, n_r - 1'b1});
  assign prod_s = a_s * signed'({1'b0, shape_size_r});

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      neg_r <= prod_s[MW-1];
      mag_r <= prod_s[MW-1] ? MW'(-prod_s) : MW'(prod_s);
    end
  end

  // serial restoring divider, also starting x of the rotation
  logic [DDW-1:0]      dq_r;
  logic [DVW-1:0]      rem_r, div_r;
  logic [DVW:0]        trial;
  logic                ge;
  logic [42:0]         gain_p;
  logic signed [ZW-1:0] x_r, y_r, z_r;
  logic [1:0]          quad_r;

  assign trial  = {rem_r, dq_r[DDW-1]};
  assign ge     = trial >= {1'b0, div_r};
  assign gain_p = shape_size_r * wpg_pkg::CORDIC_GAIN;

  // cordic step
  logic signed [ZW-1:0] xs, ys, at;
  assign xs = x_r >>> cmd.k;
  assign ys = y_r >>> cmd.k;
  assign at = ZW'(wpg_pkg::atan_entry(cmd.k));

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r <= '0;
      x_r   <= ZW'((gain_p + 43'd8192) >> 14);
      if (line_r) begin
        dq_r  <= DDW'(mag_r) + DDW'(n_r - 1'b1);
        div_r <= {n_r - 1'b1, 1'b0};
      end else begin
        dq_r  <= {1'b0, i_r, 32'd0} + DDW'(n_r >> 1);
        div_r <= {1'b0, n_r};
      end
    end else if (cmd.div_step) begin
      rem_r <= ge ? DVW'(trial - {1'b0, div_r}) : DVW'(trial);
      dq_r  <= {dq_r[DDW-2:0], ge};
    end
    if (cmd.angle) begin
      quad_r <= dq_r[31:30];
      z_r    <= ZW'(dq_r[29:0]);
      y_r    <= '0;
    end else if (cmd.rot_step) begin
      if (!z_r[ZW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  // offsets and final point
  logic signed [ZW-1:0] cc, ss;
  logic signed [ZW-1:0] cr, sr;
  logic [12:0]          half;
  logic signed [OW-1:0] dy, dz;
  logic signed [OW:0]   ty, tz;
  logic signed [14:0]   ty_sat;
  logic [14:0]          tz_sat;

  always_comb begin
    case (quad_r)
      2'd0:    begin cc = x_r;  ss = y_r;  end
      2'd1:    begin cc = -y_r; ss = x_r;  end
      2'd2:    begin cc = -x_r; ss = -y_r; end
      default: begin cc = y_r;  ss = -x_r; end
    endcase
    cr   = (cc + ZW'(32768)) >>> 16;
    sr   = (ss + ZW'(32768)) >>> 16;
    half = 13'((14'(shape_size_r) + 14'd1) >> 1);
    if (center_r) begin
      dy = '0;
      dz = '0;
    end else if (square_r) begin
      dy = (i_r == CW'(0) || i_r == CW'(3)) ? -OW'(half) : OW'(half);
      dz = (i_r < CW'(2)) ? -OW'(half) : OW'(half);
    end else if (line_r) begin
      dy = neg_r ? -OW'(dq_r[13:0]) : OW'(dq_r[13:0]);
      dz = '0;
    end else begin
      dy = OW'(cr);
      dz = OW'(sr);
    end
    ty = (OW+1)'(center_y_r) + (OW+1)'(dy);
    tz = signed'((OW+1)'(center_z_r)) + (OW+1)'(dz);
    if (ty < -(OW+1)'(16384)) ty_sat = -15'sd16384;
    else if (ty > (OW+1)'(16383)) ty_sat = 15'sd16383;
    else ty_sat = 15'(ty);
    if (tz < 0) tz_sat = 15'd0;
    else if (tz > (OW+1)'(32767)) tz_sat = 15'd32767;
    else tz_sat = 15'(tz);
  end

  // output register and position index
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
      idx_r       <= ((pos_r + 1'b1) >= cnt_r) ? '0 : pos_r + 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      target_x     <= center_x_r;
      target_y     <= ty_sat;
      target_z     <= tz_sat;
      point_number <= 7'(pos_r);
      point_count  <= 7'(cnt_r);
    end
  end

  assign out_valid    = out_valid_r;
  assign st.is_direct = center_r | square_r;
  assign st.is_line   = line_r;
  assign st.out_free  = !out_valid_r || out_ready;

endmodule

### design/waypoint_pattern_generator.sv
// top level of the waypoint pattern generator: controller plus datapath
// usage:
//   in_ch   : one request per timer tick; tick=1 asks for the next point,
//             tick=0 is taken and dropped with no result and no state change
//   out_ch  : one point per tick (x, y, z in q0.15 metres, point number, count)
//   cfg_ch  : register writes, always ready; the user must write only while no
//             request is in flight, as the block does not enforce it
// states per point, with defaults of 64 points and 16 cordic steps:
//   center point or square corner: idle, prep, done
//   line point: idle, prep, divider init, serial divide, done
//   circle point: as a line point, with angle setup and cordic rotation before done
//   one request is worked at a time; in_ch.ready is high only when idle
// reset: rst_n low clears the sequencer, position index and output valid, and
//   loads the default pattern (circle of 8 points with center first)
// stall: a finished point waits in the output register; the next request is
//   taken meanwhile and its result waits until the register is free
module waypoint_pattern_generator #(
  parameter int MAX_POINTS   = wpg_pkg::MAX_POINTS_DEF,
  parameter int CORDIC_STEPS = wpg_pkg::CORDIC_STEPS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  wpg_tick_if.sink   in_ch,
  wpg_point_if.source out_ch,
  wpg_cfg_if.sink    cfg_ch
);

  // divider runs one quotient bit per cycle over the whole dividend
  localparam int DIV_STEPS = $clog2(MAX_POINTS + 2) + 33;

  wpg_pkg::cmd_t    cmd;
  wpg_pkg::status_t st;
  logic             in_ready;
  logic             tick_req;

  // a request with tick set starts a point
  assign tick_req     = in_ch.valid && in_ready && in_ch.tick;
  assign in_ch.ready  = in_ready;
  assign cfg_ch.ready = 1'b1;

  wpg_ctrl #(
    .DIV_STEPS    (DIV_STEPS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick_req (tick_req),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  wpg_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .st           (st),
    .cfg_we       (cfg_ch.valid),
    .cfg_index    (cfg_ch.reg_index),
    .cfg_data     (cfg_ch.data),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .target_x     (out_ch.target_x),
    .target_y     (out_ch.target_y),
    .target_z     (out_ch.target_z),
    .point_number (out_ch.point_number),
    .point_count  (out_ch.point_count)
  );

endmodule

### design/wpg_checker.sv
// port-level checks of the waypoint pattern generator and their bind
`include "waypoint_pattern_generator_assert.svh"

module wpg_checker (
  input logic         clk,
  input logic         rst_n,
  wpg_tick_if.sink    in_ch,
  wpg_point_if.source out_ch
);

  // stalled result stays valid and holds its target_y
  `WPG_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.target_y))
  // stalled result keeps its point number
  `WPG_ASSERT_NEXT(a_num_hold, out_ch.valid && !out_ch.ready, $stable(out_ch.point_number))
  // one request at a time: busy after a tick starts
  `WPG_ASSERT_NEXT(a_busy_after_tick, in_ch.valid && in_ch.ready && in_ch.tick, !in_ch.ready)
  // point number lies inside the pattern
  `WPG_ASSERT_NOW(a_num_in_range, out_ch.valid, out_ch.point_number < out_ch.point_count)
  // pattern has at least four points
  `WPG_ASSERT_NOW(a_count_min, out_ch.valid, out_ch.point_count >= 7'd4)

endmodule

bind waypoint_pattern_generator wpg_checker u_wpg_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

### verif/wpg_tb_if.sv
// the channel interfaces come with the design (design/wpg_if.sv); this file holds the shared clock half period
package wpg_tb_pkg;
  localparam int CLK_HALF = 5;
endpackage

### verif/tb_top.sv
// testbench of the waypoint pattern generator: random ticks, config phases, bit-exact point check
module tb_top;

  logic clk;
  logic rst_n;

  wpg_tick_if  tick_ch ();
  wpg_point_if point_ch ();
  wpg_cfg_if   cfg_ch ();

  waypoint_pattern_generator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (tick_ch.sink),
    .out_ch (point_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // one expected point
  typedef struct {
    logic        [14:0] tx;
    logic signed [14:0] ty;
    logic        [14:0] tz;
    logic        [6:0]  num;
    logic        [6:0]  cnt;
  } point_t;

  // predictor copy of the registers and the position index
  logic [1:0]         p_mode;
  logic [14:0]        p_cx;
  logic signed [14:0] p_cy;
  logic [14:0]        p_cz;
  logic [12:0]        p_size;
  logic [6:0]         p_ppc;
  logic               p_sac;
  logic [6:0]         p_pos;

  point_t pending_points[$];
  int     fail_count;
  bit     sink_hold;     // long receiver hold-off
  bit     no_idle;       // stretch with no idling on either side

  always #(wpg_tb_pkg::CLK_HALF) clk = ~clk;

  // arithmetic floor shift of a 64 bit value
  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic logic [31:0] atan_val(int k);
    logic [31:0] t [0:23];
    t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
          32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
          32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
          32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
          32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
    return t[k];
  endfunction

  // radius * (cos, sin) of point i of n by cordic rotation
  task automatic circle_point(input int i, input int n, output longint dc, output longint ds);
    longint unsigned ph64;
    logic [31:0] phase;
    longint x, y, z, xs, ys, c, s;
    ph64  = ((longint'(i) << 32) + (n >> 1)) / n;
    phase = ph64[31:0];
    z = longint'(phase[29:0]);
    x = fshift(longint'(p_size) * 64'sd652032874 + 8192, 14);
    y = 0;
    for (int k = 0; k < wpg_pkg::CORDIC_STEPS_DEF; k++) begin
      xs = fshift(x, k);
      ys = fshift(y, k);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_val(k));
      end else begin
        x += ys; y -= xs; z += longint'(atan_val(k));
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    dc = fshift(c + 32768, 16);
    ds = fshift(s + 32768, 16);
  endtask

  // next point of the pattern; advances the position index
  task automatic predict_point(output point_t pt);
    int n, pattern, offs, count, pos, i;
    longint dy, dz, ty, tz, num, d, mag, q, h;
    n = p_ppc;
    if (n < 4) n = 4;
    if (n > wpg_pkg::MAX_POINTS_DEF) n = wpg_pkg::MAX_POINTS_DEF;
    pattern = (p_mode == wpg_pkg::MODE_SQUARE) ? 4 : n;
    offs = p_sac ? 1 : 0;
    count = pattern + offs;
    pos = (p_pos < count) ? p_pos : 0;
    dy = 0;
    dz = 0;
    if (pos >= offs) begin
      i = pos - offs;
      if (p_mode == wpg_pkg::MODE_LINE) begin
        num = (2 * longint'(i) - (n - 1)) * longint'(p_size);
        d = 2 * (n - 1);
        mag = num < 0 ? -num : num;
        q = (mag + d / 2) / d;
        dy = num < 0 ? -q : q;
      end else if (p_mode == wpg_pkg::MODE_SQUARE) begin
        h = (longint'(p_size) + 1) >> 1;
        dy = (i == 0 || i == 3) ? -h : h;
        dz = (i < 2) ? -h : h;
      end else begin
        circle_point(i, n, dy, dz);
      end
    end
    ty = longint'(p_cy) + dy;
    if (ty < -16384) ty = -16384;
    if (ty > 16383) ty = 16383;
    tz = longint'(p_cz) + dz;
    if (tz < 0) tz = 0;
    if (tz > 32767) tz = 32767;
    pt.tx  = p_cx;
    pt.ty  = ty[14:0];
    pt.tz  = tz[14:0];
    pt.num = pos[6:0];
    pt.cnt = count[6:0];
    p_pos = (pos + 1 >= count) ? 7'd0 : 7'(pos + 1);
  endtask

  // send one tick request; predicts when tick is set
  task automatic send_tick(input logic tk, input bit may_idle);
    point_t pt;
    if (may_idle && !no_idle) begin
      while ($urandom_range(99) < 34) @(negedge clk);
    end
    tick_ch.valid = 1'b1;
    tick_ch.tick  = tk;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    if (tk) begin
      predict_point(pt);
      pending_points = {pending_points, pt};
    end
    @(negedge clk);
    tick_ch.valid = 1'b0;
  endtask

  // wait until all points are back, plus the longest latency, before a register write
  task automatic drain;
    int guard;
    guard = 0;
    while (pending_points.size() != 0 && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input wpg_pkg::reg_idx_t idx, input logic [14:0] val);
    cfg_ch.valid     = 1'b1;
    cfg_ch.reg_index = idx;
    cfg_ch.data      = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      wpg_pkg::REG_SHAPE_MODE:      p_mode = val[1:0];
      wpg_pkg::REG_CENTER_X:        p_cx   = val;
      wpg_pkg::REG_CENTER_Y:        p_cy   = val;
      wpg_pkg::REG_CENTER_Z:        p_cz   = val;
      wpg_pkg::REG_SHAPE_SIZE:      p_size = val[12:0];
      wpg_pkg::REG_POINTS_PER_CYC:  p_ppc  = val[6:0];
      wpg_pkg::REG_START_AT_CENTER: p_sac  = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic set_pattern(input logic [1:0] md, input logic [14:0] cx, input logic [14:0] cy,
                             input logic [14:0] cz, input logic [12:0] sz, input logic [6:0] n,
                             input logic sac);
    drain();
    write_reg(wpg_pkg::REG_SHAPE_MODE, {13'd0, md});
    write_reg(wpg_pkg::REG_CENTER_X, cx);
    write_reg(wpg_pkg::REG_CENTER_Y, cy);
    write_reg(wpg_pkg::REG_CENTER_Z, cz);
    write_reg(wpg_pkg::REG_SHAPE_SIZE, {2'd0, sz});
    write_reg(wpg_pkg::REG_POINTS_PER_CYC, {8'd0, n});
    write_reg(wpg_pkg::REG_START_AT_CENTER, {14'd0, sac});
  endtask

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    point_t exp_pt;
    if (rst_n && point_ch.valid && point_ch.ready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point: y=%0d num=%0d", point_ch.target_y, point_ch.point_number);
        fail_count++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (point_ch.target_x !== exp_pt.tx) begin
          $error("target_x expected %0d got %0d", exp_pt.tx, point_ch.target_x); fail_count++;
        end
        if (point_ch.target_y !== exp_pt.ty) begin
          $error("target_y expected %0d got %0d", exp_pt.ty, point_ch.target_y); fail_count++;
        end
        if (point_ch.target_z !== exp_pt.tz) begin
          $error("target_z expected %0d got %0d", exp_pt.tz, point_ch.target_z); fail_count++;
        end
        if (point_ch.point_number !== exp_pt.num) begin
          $error("point_number expected %0d got %0d", exp_pt.num, point_ch.point_number);
          fail_count++;
        end
        if (point_ch.point_count !== exp_pt.cnt) begin
          $error("point_count expected %0d got %0d", exp_pt.cnt, point_ch.point_count);
          fail_count++;
        end
      end
    end
  end

  // receiver stall pattern, changed at the falling edge
  always @(negedge clk) begin
    if (sink_hold)
      point_ch.ready <= 1'b0;
    else if (no_idle)
      point_ch.ready <= 1'b1;
    else
      point_ch.ready <= ($urandom_range(99) >= 34);
  end

  // directed: defaults, then each mode at its extremes, odd sizes and wrap
  task automatic test_directed;
    repeat (10) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);              // tick zero gives nothing
    set_pattern(wpg_pkg::MODE_LINE, 15'd6554, -15'sd8192, 15'd8192, 13'd5898, 7'd4, 1'b0);
    repeat (5) send_tick(1'b1, 1'b0);
    set_pattern(wpg_pkg::MODE_SQUARE, 15'd18022, 15'sd8192, 15'd22938, 13'd5897, 7'd64, 1'b1);
    repeat (6) send_tick(1'b1, 1'b0);
    // mode three is a circle; count out of range saturates
    set_pattern(2'd3, 15'h7FFF, 15'sd16383, 15'h7FFF, 13'h1FFF, 7'h7F, 1'b0);
    repeat (3) send_tick(1'b1, 1'b0);
    set_pattern(wpg_pkg::MODE_CIRCLE, 15'd0, 15'h4000, 15'd0, 13'h1FFF, 7'd0, 1'b1);
    repeat (3) send_tick(1'b1, 1'b0);
  endtask

  // receiver holds off long while ticks keep coming, then the sender waits for all
  task automatic test_backpressure;
    set_pattern(wpg_pkg::MODE_SQUARE, 15'd11469, 15'd0, 15'd14746, 13'd328, 7'd8, 1'b1);
    fork
      begin
        sink_hold = 1'b1;
        repeat (300) @(negedge clk);
        sink_hold = 1'b0;
      end
      repeat (12) send_tick(1'b1, 1'b0);
    join
    drain();
  endtask

  // random phases, mostly legal settings with random content, some raw values
  task automatic test_random;
    int sent;
    logic [1:0] md;
    logic [6:0] n;
    sent = 0;
    while (sent < 1750) begin
      md = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
      n  = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(4, 16));
      if ($urandom_range(15) == 0) n = 7'd64;
      if ($urandom_range(4) == 0)
        set_pattern(md, 15'($urandom), 15'($urandom), 15'($urandom), 13'($urandom), n,
                    1'($urandom));
      else
        set_pattern(md, 15'($urandom_range(6554, 18022)), 15'($urandom_range(0, 16384) - 8192),
                    15'($urandom_range(8192, 22938)), 13'($urandom_range(328, 5898)), n,
                    1'($urandom));
      no_idle = ($urandom_range(5) == 0);
      repeat ($urandom_range(20, 90)) begin
        send_tick(($urandom_range(19) != 0), 1'b1);
        sent++;
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    tick_ch.valid = 1'b0;
    tick_ch.tick = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reg_index = wpg_pkg::REG_SHAPE_MODE;
    cfg_ch.data = '0;
    point_ch.ready = 1'b0;
    fail_count = 0;
    sink_hold = 1'b0;
    no_idle = 1'b0;
    p_mode = wpg_pkg::RST_SHAPE_MODE; p_cx = wpg_pkg::RST_CENTER_X;
    p_cy = wpg_pkg::RST_CENTER_Y; p_cz = wpg_pkg::RST_CENTER_Z;
    p_size = wpg_pkg::RST_SHAPE_SIZE; p_ppc = wpg_pkg::RST_PPC; p_sac = wpg_pkg::RST_SAC;
    p_pos = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    if (fail_count == 0 && pending_points.size() == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // run limit: 1750 ticks under stalls, with margin
  initial begin
    #(40_000_000);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/wpg_pkg.sv
design/wpg_if.sv
design/wpg_ctrl.sv
design/wpg_dp.sv
design/waypoint_pattern_generator.sv
design/wpg_checker.sv
verif/wpg_tb_if.sv
verif/tb_top.sv
